/* hw/rtl/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and helpers for the URI percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LF  = 8'h66;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // escape phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_DIG  = 3'b100
  } phase_t;

  // bytes produced by one accepted item (cnt is 1..3)
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            eos;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (b >= CH_0 && b <= CH_9) begin
      r.ok  = 1'b1;
      r.val = 4'(b - CH_0);
    end else if (b >= CH_LA && b <= CH_LF) begin
      r.ok  = 1'b1;
      r.val = 4'(b - CH_LA + 8'd10);
    end else if (b >= CH_UA && b <= CH_UF) begin
      r.ok  = 1'b1;
      r.val = 4'(b - CH_UA + 8'd10);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/upd_front.sv */
// ----------------------------------------------------------------------------
// upd_front
// Accepts input bytes, runs the escape state and builds one job per item that yields bytes.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    in_byte,
  input  logic          in_end_of_string,
  output logic          job_push,
  output upd_pkg::job_t job,
  input  logic          q_full
);
  import upd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [2:0][7:0] eb;
  logic [1:0] n;
  hex_t       hb, hh;
  logic       acc;

  assign full = q_full;
  assign acc  = push && !q_full;
  assign hb   = hex_decode(in_byte);
  assign hh   = hex_decode(held_r);

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    eb        = '0;
    n         = 2'd0;
    unique case (phase_r)
      PH_PCT: begin
        if (hb.ok) begin
          held_nxt  = in_byte;
          phase_nxt = PH_DIG;
        end else if (in_byte == CH_PCT) begin
          eb[0]     = CH_PCT;
          n         = 2'd1;
          phase_nxt = PH_IDLE;
        end else begin
          // broken escape: literal '%', then the byte as fresh input
          eb[0]     = CH_PCT;
          eb[1]     = in_byte;
          n         = 2'd2;
          phase_nxt = PH_IDLE;
        end
      end
      PH_DIG: begin
        if (hb.ok && hh.ok) begin
          eb[0]     = {hh.val, hb.val};
          n         = 2'd1;
          phase_nxt = PH_IDLE;
        end else begin
          eb[0] = CH_PCT;
          eb[1] = held_r;
          if (in_byte == CH_PCT) begin
            n         = 2'd2;
            phase_nxt = PH_PCT;
          end else begin
            eb[2]     = in_byte;
            n         = 2'd3;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        if (in_byte == CH_PCT) begin
          phase_nxt = PH_PCT;
        end else begin
          eb[0]     = in_byte;
          n         = 2'd1;
          phase_nxt = PH_IDLE;
        end
      end
    endcase

    // flush an open escape at end of string
    if (in_end_of_string) begin
      if (phase_nxt == PH_PCT) begin
        eb[n] = CH_PCT;
        n     = n + 2'd1;
      end else if (phase_nxt == PH_DIG) begin
        eb[n]         = CH_PCT;
        eb[n + 2'd1]  = held_nxt;
        n             = n + 2'd2;
      end
      phase_nxt = PH_IDLE;
      held_nxt  = 8'd0;
    end
  end

  assign job.bytes = eb;
  assign job.cnt   = n;
  assign job.eos   = in_end_of_string;
  assign job_push  = acc && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

/* hw/rtl/upd_queue.sv */
// ----------------------------------------------------------------------------
// upd_queue
// Short job queue decoupling the front from the output serialiser.
// ----------------------------------------------------------------------------
module upd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  upd_pkg::job_t wr_job,
  output logic          q_full,
  input  logic          rd_en,
  output upd_pkg::job_t rd_job,
  output logic          q_empty
);
  import upd_pkg::*;

  job_t           slots_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign q_full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_job  = slots_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
    end
  end

endmodule

/* hw/rtl/upd_back.sv */
// ----------------------------------------------------------------------------
// upd_back
// Takes jobs from the queue and presents their bytes one per cycle while pop is held.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  upd_pkg::job_t q_job,
  output logic          q_rd,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          out_run_last,
  output logic          out_string_done
);
  import upd_pkg::*;

  job_t       job_r;
  logic       vld_r;
  logic [1:0] idx_r;
  logic       last, take;

  assign last  = (idx_r == job_r.cnt - 2'd1);
  assign take  = vld_r && pop;
  // reload when the holding register is free or its final byte leaves
  assign q_rd  = !q_empty && (!vld_r || (take && last));

  assign empty           = !vld_r;
  assign out_byte        = job_r.bytes[idx_r];
  assign out_run_last    = last;
  assign out_string_done = last && job_r.eos;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      job_r <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (q_rd) begin
      vld_r <= 1'b1;
      idx_r <= 2'd0;
    end else if (take) begin
      if (last) begin
        vld_r <= 1'b0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

/* hw/rtl/uri_percent_decoder.sv */
// ----------------------------------------------------------------------------
// uri_percent_decoder
// Streaming URI percent-escape decoder, one encoded byte per item.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | push / full        | in_byte, in_end_of_string
//  result  | pop / empty        | out_byte, out_run_last, out_string_done
//
//  One input item is taken per cycle while the four-entry job queue has room.
//  Each item yields 0 to 3 bytes; the output side delivers one byte a cycle while pop
//  is held, so items that expand (broken escapes, flushes) hold up the queue longer.
//  An accepted item's job is written to the queue, then to the back's holding register.
//  Reset (rst_n low, synchronous) returns the escape state to idle and
//  drops all queued results. Output stalls only back up into full.
// ----------------------------------------------------------------------------
module uri_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_done
);
  import upd_pkg::*;

  job_t fjob, qjob;
  logic fpush, q_full, q_empty, q_rd;

  upd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_end_of_string(in_end_of_string),
    .job_push        (fpush),
    .job             (fjob),
    .q_full          (q_full)
  );

  upd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (fpush),
    .wr_job (fjob),
    .q_full (q_full),
    .rd_en  (q_rd),
    .rd_job (qjob),
    .q_empty(q_empty)
  );

  upd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_job          (qjob),
    .q_rd           (q_rd),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_done(out_string_done)
  );

endmodule

/* hw/rtl/upd_checker.sv */
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks for the URI percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module upd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_string_done
);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) &&
                          $stable(out_run_last) && $stable(out_string_done)))
    else $error("result changed while stalled");

  // end of string always closes an item's run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_string_done) |-> out_run_last)
    else $error("string_done without run_last");

  // reset leaves nothing to deliver
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result pending after reset");

  // queue is free right after reset
  a_rst_room: assert property (@(posedge clk)
    !rst_n |=> !full)
    else $error("full after reset");

endmodule

bind uri_percent_decoder upd_checker u_upd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .out_byte       (out_byte),
  .out_run_last   (out_run_last),
  .out_string_done(out_string_done)
);
